### src/altitude_climb_descent_detector_macros.svh
// assertion macros for the altitude climb / descent detector
`ifndef ALTITUDE_CLIMB_DESCENT_DETECTOR_MACROS_SVH
`define ALTITUDE_CLIMB_DESCENT_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF
`define ACD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("acd assertion failed");
`define ACD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acd assertion failed");
`else
`define ACD_ASSERT(name, prop)
`define ACD_ASSERT_IMP(name, ante, cons)
`endif

`endif

### src/acd_pkg.sv
// shared widths, codes and types of the altitude climb / descent detector
package acd_pkg;

  localparam int unsigned ALT_W   = 24;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned ACC_W   = ALT_W + FRAC_W;
  localparam int unsigned ALPHA_W = 16;
  localparam int unsigned THR_W   = 21;
  localparam int unsigned CFG_W   = 21;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DELTA_W = ALT_W + 1;
  localparam int unsigned RUN_LEN = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(58982);
  localparam logic signed [THR_W-1:0] RISE_RST = THR_W'(50);
  localparam logic signed [THR_W-1:0] FALL_RST = -THR_W'(50);

  typedef enum logic [1:0] {
    POSE_UNKNOWN = 2'd0,
    POSE_RISING  = 2'd1,
    POSE_FALLING = 2'd2
  } pose_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_RISE  = 2'd1,
    CFG_FALL  = 2'd2
  } cfg_idx_e;

endpackage

### src/acd_channels.sv
// valid / ready channels for altitude samples and detector results
interface acd_in_if;
  logic valid;
  logic ready;
  logic signed [acd_pkg::ALT_W-1:0] altitude_cm;

  modport source (output valid, output altitude_cm, input ready);
  modport sink (input valid, input altitude_cm, output ready);
endinterface

interface acd_out_if;
  logic valid;
  logic ready;
  logic signed [acd_pkg::ALT_W-1:0] smoothed_altitude_cm;
  acd_pkg::pose_e pose;

  modport source (output valid, output smoothed_altitude_cm, output pose, input ready);
  modport sink (input valid, input smoothed_altitude_cm, input pose, output ready);
endinterface

### src/altitude_climb_descent_detector.sv
// top level: input register, smoothing and slope logic, result register, config
//
//  channel  | dir | payload                           | handshake
//  in_if    | in  | altitude_cm                       | valid / ready
//  out_if   | out | smoothed_altitude_cm, pose        | valid / ready
//  cfg      | in  | cfg_idx_i, cfg_data_i             | cfg_we_i, no wait
//
// one item per cycle sustained while out_if does not stall; each item goes from the
// input register through one multiply-add and compares into the result register
// in_if.ready follows out_if.ready through the same cycle, so a stall on the output
// holds both registers and backs up to the input after one more item
// reset clears the average, the history and both valid flags and loads the
// default alpha and thresholds
`include "altitude_climb_descent_detector_macros.svh"

module altitude_climb_descent_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  acd_in_if.sink                             in_if,
  acd_out_if.source                          out_if,
  input  logic                               cfg_we_i,
  input  logic [acd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [acd_pkg::CFG_W-1:0]          cfg_data_i
);

  logic [acd_pkg::ALPHA_W-1:0]       alpha_q;
  logic signed [acd_pkg::THR_W-1:0]  rise_thr_q;
  logic signed [acd_pkg::THR_W-1:0]  fall_thr_q;

  logic                              in_valid_q;
  logic signed [acd_pkg::ALT_W-1:0]  alt_q;
  logic                              out_valid_q;
  logic signed [acd_pkg::ALT_W-1:0]  smooth_q;
  acd_pkg::pose_e                    pose_q;

  logic                              advance;
  logic signed [acd_pkg::ALT_W-1:0]  smoothed;
  logic                              seen_first;
  acd_pkg::pose_e                    pose;

  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= acd_pkg::ALPHA_RST;
      rise_thr_q <= acd_pkg::RISE_RST;
      fall_thr_q <= acd_pkg::FALL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        acd_pkg::CFG_ALPHA: alpha_q    <= cfg_data_i[acd_pkg::ALPHA_W-1:0];
        acd_pkg::CFG_RISE:  rise_thr_q <= cfg_data_i[acd_pkg::THR_W-1:0];
        acd_pkg::CFG_FALL:  fall_thr_q <= cfg_data_i[acd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      alt_q <= in_if.altitude_cm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      smooth_q <= smoothed;
      pose_q   <= pose;
    end
  end

  acd_ema u_ema (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .sample_i     (alt_q),
    .alpha_i      (alpha_q),
    .smoothed_o   (smoothed),
    .seen_first_o (seen_first)
  );

  acd_slope u_slope (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .seen_first_i (seen_first),
    .smoothed_i   (smoothed),
    .rise_thr_i   (rise_thr_q),
    .fall_thr_i   (fall_thr_q),
    .pose_o       (pose)
  );

  assign out_if.valid                = out_valid_q;
  assign out_if.smoothed_altitude_cm = smooth_q;
  assign out_if.pose                 = pose_q;

  `ACD_ASSERT_IMP(a_seen_sticky, seen_first, seen_first)
  `ACD_ASSERT_IMP(a_hold_input, in_valid_q && !advance, in_valid_q && $stable(alt_q))
  `ACD_ASSERT_IMP(a_advance_shows, advance, out_valid_q)
  `ACD_ASSERT_IMP(a_first_unknown, advance && !seen_first, pose_q == acd_pkg::POSE_UNKNOWN)

endmodule

### src/acd_ema.sv
// exponential moving average: accumulator state and its one-multiply update
module acd_ema (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic signed [acd_pkg::ALT_W-1:0]    sample_i,
  input  logic [acd_pkg::ALPHA_W-1:0]         alpha_i,
  output logic signed [acd_pkg::ALT_W-1:0]    smoothed_o,
  output logic                                seen_first_o
);

  localparam int unsigned DW = acd_pkg::ACC_W + 1;
  localparam int unsigned WW = acd_pkg::ALPHA_W + 1;
  localparam int unsigned PW = DW + WW + 1;

  logic signed [acd_pkg::ACC_W-1:0] acc_q, acc_d;
  logic                             seen_q;
  logic signed [acd_pkg::ACC_W-1:0] scaled;
  logic signed [DW-1:0]             diff;
  logic [WW-1:0]                    weight;
  logic signed [PW-1:0]             prod;
  logic signed [DW-1:0]             sum;

  assign scaled = {sample_i, {acd_pkg::FRAC_W{1'b0}}};
  assign diff   = {scaled[acd_pkg::ACC_W-1], scaled} - {acc_q[acd_pkg::ACC_W-1], acc_q};
  // weight on the new sample is one minus alpha
  assign weight = {1'b1, {acd_pkg::ALPHA_W{1'b0}}} - {1'b0, alpha_i};
  assign prod   = PW'(diff) * $signed({1'b0, weight});
  // floor of the product over 2^16, then back onto the old average
  assign sum    = {acc_q[acd_pkg::ACC_W-1], acc_q} + prod[DW+acd_pkg::ALPHA_W-1:acd_pkg::ALPHA_W];

  always_comb begin
    if (seen_q) begin
      acc_d = sum[acd_pkg::ACC_W-1:0];
    end else begin
      acc_d = scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      seen_q <= 1'b0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      seen_q <= 1'b1;
    end
  end

  assign smoothed_o   = acc_d[acd_pkg::ACC_W-1:acd_pkg::FRAC_W];
  assign seen_first_o = seen_q;

endmodule

### src/acd_slope.sv
// slope qualifier: change since the previous sample and three-in-a-row runs
module acd_slope (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic                               seen_first_i,
  input  logic signed [acd_pkg::ALT_W-1:0]   smoothed_i,
  input  logic signed [acd_pkg::THR_W-1:0]   rise_thr_i,
  input  logic signed [acd_pkg::THR_W-1:0]   fall_thr_i,
  output acd_pkg::pose_e                     pose_o
);

  logic signed [acd_pkg::ALT_W-1:0]   prev_q;
  logic [acd_pkg::RUN_LEN-2:0]        rise_hist_q;
  logic [acd_pkg::RUN_LEN-2:0]        fall_hist_q;
  logic signed [acd_pkg::DELTA_W-1:0] delta;
  logic                               rise_now;
  logic                               fall_now;
  logic [acd_pkg::RUN_LEN-1:0]        rise_run;
  logic [acd_pkg::RUN_LEN-1:0]        fall_run;

  always_comb begin
    if (seen_first_i) begin
      delta = acd_pkg::DELTA_W'(smoothed_i) - acd_pkg::DELTA_W'(prev_q);
    end else begin
      delta = '0;
    end
  end

  assign rise_now = delta > acd_pkg::DELTA_W'(rise_thr_i);
  assign fall_now = delta < acd_pkg::DELTA_W'(fall_thr_i);
  assign rise_run = {rise_hist_q, rise_now};
  assign fall_run = {fall_hist_q, fall_now};

  // rising wins when both runs are complete
  always_comb begin
    if (&rise_run) begin
      pose_o = acd_pkg::POSE_RISING;
    end else if (&fall_run) begin
      pose_o = acd_pkg::POSE_FALLING;
    end else begin
      pose_o = acd_pkg::POSE_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      rise_hist_q <= '0;
      fall_hist_q <= '0;
    end else if (step_i) begin
      prev_q      <= smoothed_i;
      rise_hist_q <= rise_run[acd_pkg::RUN_LEN-2:0];
      fall_hist_q <= fall_run[acd_pkg::RUN_LEN-2:0];
    end
  end

endmodule
